@@ hw/rtl/hvt_pkg.sv @@
// hvt_pkg: shared types and constants for the homogeneous vertex transform
// no dependencies
`timescale 1ns / 1ps
package hvt_pkg;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CompW   = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned SumW    = 66;
  localparam int unsigned DivW    = 56;   // |x| << frac fits with frac up to 24
  localparam int unsigned QW      = DivW; // quotient width

  typedef logic signed [CompW-1:0] comp_t;
  typedef comp_t vec4_t [4];

  // row-major matrix entry type
  typedef comp_t mat_t [4][4];
endpackage

@@ hw/rtl/homogeneous_vertex_transform_unit.sv @@
// homogeneous_vertex_transform_unit: 4x4 matrix times point, then perspective divide
// depends on hvt_pkg
//
//  channel | dir | handshake            | word
//  in_     | in  | in_tvalid/in_tready  | tdata {w,z,y,x}, tuser use_transpose
//  out_    | out | out_tvalid/out_tready| tdata {w,z,y,x}, tuser normalized
//  cfg_    | in  | cfg_we               | cfg_idx selects one of eight 64-bit regs
//
// one word per cycle sustained while the output is not stalled; the pipe depth is
// set by the radix-2 restoring divider which retires one quotient bit per stage
// reset clears all valid bits and loads the identity matrix
// the whole pipeline advances together; a stall at the output freezes every
// stage, so bubbles inside the pipe are not squeezed out while it stalls
`timescale 1ns / 1ps
module homogeneous_vertex_transform_unit
  import hvt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int EPS_LSB   = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [127:0]          in_tdata,   // x_in, y_in, z_in, w_in
  input  logic                  in_tuser,   // use_transpose
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [127:0]          out_tdata,  // x_out, y_out, z_out, w_out
  output logic                  out_tuser,  // normalized
  input  logic                  cfg_we,
  input  logic [RegIdxW-1:0]    cfg_idx,
  input  logic [63:0]           cfg_wdata
);
  // number of pipeline stages: mult, sum, round, divider bits, output
  localparam int NDIV = DivW;
  localparam int NST  = 3 + NDIV + 1;
  localparam logic [SumW-1:0] HALF = SumW'(1) << (FRAC_BITS - 1);
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [63:0] cfg_r [NumRegs];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= 64'(1) << (32 + FRAC_BITS);
      cfg_r[1] <= '0;
      cfg_r[2] <= 64'(1) << FRAC_BITS;
      cfg_r[3] <= '0;
      cfg_r[4] <= '0;
      cfg_r[5] <= 64'(1) << (32 + FRAC_BITS);
      cfg_r[6] <= '0;
      cfg_r[7] <= 64'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  // matrix as entries, entry (r,c)
  mat_t m;
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = comp_t'(cfg_r[2*r][63:32]);
      m[r][1] = comp_t'(cfg_r[2*r][31:0]);
      m[r][2] = comp_t'(cfg_r[2*r+1][63:32]);
      m[r][3] = comp_t'(cfg_r[2*r+1][31:0]);
    end
  end

  // pipeline enable: stages shift when the tail is free or empty
  logic [NST-1:0] vld_r;
  logic adv;
  assign adv       = out_tready || !vld_r[NST-1];
  assign in_tready = adv;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  // stage 1: sixteen products
  logic signed [ProdW-1:0] prod_r [4][4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= (in_tuser ? m[j][i] : m[i][j])
                          * $signed(in_tdata[32*j +: 32]);
        end
      end
    end
  end

  // stage 2: exact sums plus rounding half
  logic signed [SumW-1:0] sum_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= SumW'(prod_r[i][0]) + SumW'(prod_r[i][1])
                  + SumW'(prod_r[i][2]) + SumW'(prod_r[i][3])
                  + $signed(HALF);
      end
    end
  end

  // stage 3: shift, saturate, near-zero test and divider setup
  logic signed [SumW-1:0] sh [4];
  comp_t rnd [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = sum_r[i] >>> FRAC_BITS;
      if (sh[i] > $signed(SumW'(32'h7fffffff)))       rnd[i] = 32'sh7fffffff;
      else if (sh[i] < -$signed(SumW'(33'h80000000))) rnd[i] = 32'sh80000000;
      else                                             rnd[i] = comp_t'(sh[i]);
    end
  end

  logic [32:0] aw;
  assign aw = rnd[3][31] ? 33'(-$signed({rnd[3][31], rnd[3]})) : {1'b0, rnd[3]};

  // divider state per stage: partial remainders, numerators, quotients
  logic [DivW-1:0] rem_r [NDIV+1][3];
  logic [DivW-1:0] num_r [NDIV+1][3];
  logic [QW-1:0]   quo_r [NDIV+1][3];
  logic [32:0]     den_r [NDIV+1];
  logic [2:0]      neg_r [NDIV+1];
  logic            nrm_r [NDIV+1];
  comp_t           raw_r [NDIV+1][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [32:0] an;
        an = rnd[i][31] ? 33'(-$signed({rnd[i][31], rnd[i]})) : {1'b0, rnd[i]};
        // rounding: add half divisor to the shifted numerator
        num_r[0][i] <= (DivW'(an) << FRAC_BITS) + DivW'(aw >> 1);
        rem_r[0][i] <= '0;
        quo_r[0][i] <= '0;
        neg_r[0][i] <= rnd[i][31] ^ rnd[3][31];
        raw_r[0][i] <= rnd[i];
      end
      raw_r[0][3] <= rnd[3];
      den_r[0]    <= aw;
      nrm_r[0]    <= (aw > 33'(EPS_LSB));
    end
  end

  // one quotient bit per stage, restoring
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          logic [DivW:0] t;
          t = {rem_r[s][i], num_r[s][i][DivW-1]};
          if (t >= (DivW+1)'(den_r[s])) begin
            rem_r[s+1][i] <= DivW'(t - (DivW+1)'(den_r[s]));
            quo_r[s+1][i] <= {quo_r[s][i][QW-2:0], 1'b1};
          end else begin
            rem_r[s+1][i] <= DivW'(t);
            quo_r[s+1][i] <= {quo_r[s][i][QW-2:0], 1'b0};
          end
          num_r[s+1][i] <= num_r[s][i] << 1;
          neg_r[s+1][i] <= neg_r[s][i];
          raw_r[s+1][i] <= raw_r[s][i];
        end
        raw_r[s+1][3] <= raw_r[s][3];
        den_r[s+1]    <= den_r[s];
        nrm_r[s+1]    <= nrm_r[s];
      end
    end
  end

  // output stage: sign, saturate, select
  logic [127:0] dat_r;
  logic         nrm_o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [QW-1:0] q;
        q = quo_r[NDIV][i];
        if (!nrm_r[NDIV])           dat_r[32*i +: 32] <= raw_r[NDIV][i];
        else if (q >= QW'(33'h80000000))
          dat_r[32*i +: 32] <= neg_r[NDIV][i] ? 32'h80000000 : 32'h7fffffff;
        else
          dat_r[32*i +: 32] <= neg_r[NDIV][i] ? 32'(-q[31:0]) : q[31:0];
      end
      dat_r[127:96] <= nrm_r[NDIV] ? ONE : raw_r[NDIV][3];
      nrm_o_r       <= nrm_r[NDIV];
    end
  end

  assign out_tdata = dat_r;
  assign out_tuser = nrm_o_r;

  // held output word stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  // normalized results always carry w of one
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[127:96] == ONE)
    else $error("normalized w is not one");
  // a stall never drops the valid pipe
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved while stalled");
endmodule
